// ===== sv/fractal_value_noise_2d_core_assert.svh =====
// ----------------------------------------------------------------------------
// fractal value noise assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_2D_CORE_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_2D_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FVN_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);
`define FVN_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);
`else
`define FVN_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg)
`define FVN_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg)
`endif
`endif

// ===== sv/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fractal value noise package
// widths, octave task type, hash constants and cosine ramp table
// ----------------------------------------------------------------------------
`default_nettype none
package fvn_pkg;

    localparam int MAX_OCTAVES  = 8;
    localparam int RAMP_ENTRIES = 1024;
    localparam int FRAC_BITS    = 16;

    localparam int RAMP_AW    = $clog2(RAMP_ENTRIES);
    localparam int OCT_W      = $clog2(MAX_OCTAVES) + 1;
    localparam int COORD_W    = 32;
    localparam int SCALED_W   = COORD_W + MAX_OCTAVES - 1;
    localparam int CNT_W      = 4;
    localparam int PERS_W     = 16;
    localparam int OUT_W      = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LAT_W      = 32;
    localparam int RAMP_W     = 16;
    localparam int SM_W       = 36;
    localparam int DIFF_W     = SM_W + 1;
    localparam int PROD_W     = DIFF_W + RAMP_W + 1;
    localparam int OCTV_SH    = 14;
    localparam int OCTV_W     = SM_W - OCTV_SH;
    localparam int AMP_FRAC   = 20;
    localparam int AMP_W      = AMP_FRAC + MAX_OCTAVES;
    localparam int PERS_FRAC  = 15;
    localparam int TERM_W     = OCTV_W + AMP_W + 1;
    localparam int TOT_W      = TERM_W + $clog2(MAX_OCTAVES) + 1;
    localparam int RES_SH     = 24;
    localparam int RES_W      = TOT_W - RES_SH;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int GRID_N     = 16;
    localparam int GRID_W     = $clog2(GRID_N);

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0]  OCT_RESET  = CNT_W'(1);
    localparam logic [PERS_W-1:0] PERS_RESET = PERS_W'(16384);

    localparam logic [LAT_W-1:0] HASH_K1   = 32'd15731;
    localparam logic [LAT_W-1:0] HASH_K2   = 32'd789221;
    localparam logic [LAT_W-1:0] HASH_K3   = 32'd1376312589;
    localparam logic [LAT_W-1:0] HASH_MASK = 32'h7fffffff;
    localparam logic [LAT_W-1:0] ONE_Q30   = 32'h40000000;

    typedef struct packed {
        logic [COORD_W-1:0] ix;
        logic [COORD_W-1:0] iy;
        logic [RAMP_AW-1:0] fx;
        logic [RAMP_AW-1:0] fy;
        logic               first;
        logic               last;
        logic               empty;
    } t_oct_task;

    typedef enum logic {
        F_IDLE,
        F_RUN
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_HASH,
        B_WAIT,
        B_TOP,
        B_BOT,
        B_MIX,
        B_VAL,
        B_OCT,
        B_ACC,
        B_AMP,
        B_OUT
    } t_back_state;

    typedef logic [RAMP_W-1:0] t_ramp [RAMP_ENTRIES];

    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint          ONE_Q30L = 64'sd1073741824;

    function automatic longint unsigned taylor_div(input longint unsigned q, input int n);
        longint unsigned r;
        unique case (n)
            1:       r = q / 2;
            2:       r = q / 12;
            3:       r = q / 30;
            4:       r = q / 56;
            5:       r = q / 90;
            6:       r = q / 132;
            7:       r = q / 182;
            8:       r = q / 240;
            9:       r = q / 306;
            default: r = q / 380;
        endcase
        return r;
    endfunction

    function automatic t_ramp build_ramp();
        t_ramp           r;
        longint unsigned m;
        longint unsigned theta;
        longint unsigned th2;
        longint unsigned mag;
        longint          c;
        longint          f;
        for (int k = 0; k < RAMP_ENTRIES; k++) begin
            m     = (2 * k <= RAMP_ENTRIES) ? longint'(k) : longint'(RAMP_ENTRIES - k);
            theta = (PI_Q30 * m) / RAMP_ENTRIES;
            th2   = (theta * theta) >> 30;
            mag   = longint'(ONE_Q30L);
            c     = ONE_Q30L;
            for (int n = 1; n <= 10; n++) begin
                mag = taylor_div((mag * th2) >> 30, n);
                if (n % 2 == 1) begin
                    c = c - longint'(mag);
                end else begin
                    c = c + longint'(mag);
                end
            end
            if (2 * k > RAMP_ENTRIES) begin
                c = -c;
            end
            f = (ONE_Q30L - c + 64'sd16384) >>> 15;
            if (f < 0) begin
                f = 0;
            end
            if (f > 65535) begin
                f = 65535;
            end
            r[k] = RAMP_W'(f);
        end
        return r;
    endfunction

    localparam t_ramp RAMP_ROM = build_ramp();

endpackage
`default_nettype wire

// ===== sv/fractal_value_noise_2d_core.sv =====
// each octave takes its 16 lattice hashes through the shared hash pipeline; a new
// coordinate is accepted while earlier octave tasks are still queued
// reset: synchronous active low, registers back to octave_count 1, persistence 0.5
// results are shown for one cycle and the receiver cannot stall
// ----------------------------------------------------------------------------
// fractal value noise core
// octave splitter, task queue and octave engine with configuration registers
// ----------------------------------------------------------------------------
`default_nettype none
module fractal_value_noise_2d_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_cfg_we,
    input  wire logic [fvn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fvn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic signed [fvn_pkg::COORD_W-1:0] i_x_coord,
    input  wire logic signed [fvn_pkg::COORD_W-1:0] i_y_coord,
    output logic                                 o_noise_strobe,
    output logic signed [fvn_pkg::OUT_W-1:0]     o_noise_total
);

    logic [fvn_pkg::CNT_W-1:0]  r_octave_count;
    logic [fvn_pkg::PERS_W-1:0] r_persistence;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_empty;
    fvn_pkg::t_oct_task         f_task;
    fvn_pkg::t_oct_task         q_task;
    logic [fvn_pkg::OUT_W-1:0]  total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= fvn_pkg::OCT_RESET;
            r_persistence  <= fvn_pkg::PERS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fvn_pkg::CFG_OCTAVES) begin
                r_octave_count <= i_cfg_data[fvn_pkg::CNT_W-1:0];
            end else if (i_cfg_idx == fvn_pkg::CFG_PERSIST) begin
                r_persistence <= i_cfg_data[fvn_pkg::PERS_W-1:0];
            end
        end
    end

    fvn_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_octave_count (r_octave_count),
        .i_q_full       (q_full),
        .o_busy         (busy),
        .o_push         (push),
        .o_task         (f_task)
    );

    fvn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_task),
        .i_pop   (pop),
        .o_data  (q_task),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fvn_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_task        (q_task),
        .i_q_empty     (q_empty),
        .i_persistence (r_persistence),
        .o_pop         (pop),
        .o_strobe      (o_noise_strobe),
        .o_noise_total (total)
    );

    assign o_noise_total = $signed(total);

endmodule
`default_nettype wire

// ===== sv/fvn_queue.sv =====
// ----------------------------------------------------------------------------
// octave task queue
// small fifo between the coordinate splitter and the octave engine
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire fvn_pkg::t_oct_task i_data,
    input  wire logic               i_pop,
    output fvn_pkg::t_oct_task      o_data,
    output logic                    o_full,
    output logic                    o_empty
);

    fvn_pkg::t_oct_task           r_mem [fvn_pkg::QDEPTH];
    logic [fvn_pkg::QAW-1:0]      r_wp;
    logic [fvn_pkg::QAW-1:0]      r_rp;
    logic [fvn_pkg::QAW:0]        r_cnt;
    logic [fvn_pkg::QAW:0]        n_cnt;

    assign o_full  = (r_cnt == (fvn_pkg::QAW + 1)'(fvn_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fvn_front.sv =====
// ----------------------------------------------------------------------------
// fractal value noise front end
// accepts a coordinate and emits one lattice task per octave, or one empty task for zero octaves
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [fvn_pkg::COORD_W-1:0] i_x_coord,
    input  wire logic [fvn_pkg::COORD_W-1:0] i_y_coord,
    input  wire logic [fvn_pkg::CNT_W-1:0]   i_octave_count,
    input  wire logic                        i_q_full,
    output logic                             o_busy,
    output logic                             o_push,
    output fvn_pkg::t_oct_task               o_task
);

    fvn_pkg::t_front_state          r_state;
    fvn_pkg::t_front_state          n_state;
    logic [fvn_pkg::COORD_W-1:0]    r_x;
    logic [fvn_pkg::COORD_W-1:0]    r_y;
    logic [fvn_pkg::OCT_W-1:0]      r_cnt;
    logic [fvn_pkg::OCT_W-1:0]      r_oct;
    logic                           accept;
    logic                           last;
    logic [fvn_pkg::OCT_W-1:0]      cnt_clip;
    logic [fvn_pkg::COORD_W-1:0]    ix;
    logic [fvn_pkg::COORD_W-1:0]    iy;
    logic [fvn_pkg::RAMP_AW-1:0]    fx;
    logic [fvn_pkg::RAMP_AW-1:0]    fy;

    function automatic void split_coord(
        input  logic [fvn_pkg::COORD_W-1:0] c,
        input  logic [fvn_pkg::OCT_W-1:0]   sh,
        output logic [fvn_pkg::COORD_W-1:0] ip,
        output logic [fvn_pkg::RAMP_AW-1:0] idx
    );
        logic signed [fvn_pkg::SCALED_W-1:0]            sc;
        logic [fvn_pkg::SCALED_W-1:0]                   mag;
        logic [fvn_pkg::COORD_W-1:0]                    ipabs;
        logic [fvn_pkg::FRAC_BITS+fvn_pkg::RAMP_AW:0]   w;
        sc    = fvn_pkg::SCALED_W'($signed(c)) <<< sh;
        mag   = sc[fvn_pkg::SCALED_W-1] ? fvn_pkg::SCALED_W'(-sc) : fvn_pkg::SCALED_W'(sc);
        ipabs = fvn_pkg::COORD_W'(mag[fvn_pkg::SCALED_W-1:fvn_pkg::FRAC_BITS]);
        ip    = sc[fvn_pkg::SCALED_W-1] ? (~ipabs + 1'b1) : ipabs;
        w     = (fvn_pkg::FRAC_BITS + fvn_pkg::RAMP_AW + 1)'(mag[fvn_pkg::FRAC_BITS-1:0])
              * (fvn_pkg::FRAC_BITS + fvn_pkg::RAMP_AW + 1)'(fvn_pkg::RAMP_ENTRIES);
        idx   = w[fvn_pkg::FRAC_BITS +: fvn_pkg::RAMP_AW];
    endfunction

    assign accept = i_start && (r_state == fvn_pkg::F_IDLE);
    assign last   = (r_cnt == '0) || (r_oct == r_cnt - 1'b1);
    assign cnt_clip = (i_octave_count > fvn_pkg::CNT_W'(fvn_pkg::MAX_OCTAVES))
                    ? fvn_pkg::OCT_W'(fvn_pkg::MAX_OCTAVES)
                    : fvn_pkg::OCT_W'(i_octave_count);

    always_comb begin
        split_coord(r_x, r_oct, ix, fx);
        split_coord(r_y, r_oct, iy, fy);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fvn_pkg::F_IDLE: begin
                if (i_start) begin
                    n_state = fvn_pkg::F_RUN;
                end
            end
            fvn_pkg::F_RUN: begin
                if (!i_q_full && last) begin
                    n_state = fvn_pkg::F_IDLE;
                end
            end
            default: n_state = fvn_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_busy       = (r_state == fvn_pkg::F_RUN);
        o_push       = (r_state == fvn_pkg::F_RUN) && !i_q_full;
        o_task.ix    = ix;
        o_task.iy    = iy;
        o_task.fx    = fx;
        o_task.fy    = fy;
        o_task.first = (r_oct == '0);
        o_task.last  = last;
        o_task.empty = (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fvn_pkg::F_IDLE;
            r_oct   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_oct <= '0;
                r_cnt <= cnt_clip;
            end else if (o_push) begin
                r_oct <= r_oct + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_x_coord;
            r_y <= i_y_coord;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fvn_hash.sv =====
// ----------------------------------------------------------------------------
// lattice hash pipeline
// four stage integer hash, one lattice point per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_hash (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic [fvn_pkg::LAT_W-1:0]          i_x,
    input  wire logic [fvn_pkg::LAT_W-1:0]          i_y,
    input  wire logic [fvn_pkg::GRID_W-1:0]         i_tag,
    output logic                                    o_valid,
    output logic [fvn_pkg::GRID_W-1:0]              o_tag,
    output logic signed [fvn_pkg::LAT_W-1:0]        o_value
);

    logic [3:0]                     r_vld;
    logic [fvn_pkg::GRID_W-1:0]     r_tag [4];
    logic [fvn_pkg::LAT_W-1:0]      r_n1;
    logic [fvn_pkg::LAT_W-1:0]      r_n2;
    logic [fvn_pkg::LAT_W-1:0]      r_n3;
    logic [fvn_pkg::LAT_W-1:0]      r_nn;
    logic [fvn_pkg::LAT_W-1:0]      r_t3;
    logic [fvn_pkg::LAT_W-1:0]      r_t4;
    logic [fvn_pkg::LAT_W-1:0]      n0;

    assign n0      = i_x + i_y * fvn_pkg::HASH_K1;
    assign o_valid = r_vld[3];
    assign o_tag   = r_tag[3];
    assign o_value = $signed(fvn_pkg::ONE_Q30 - r_t4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
        r_tag[3] <= r_tag[2];
        r_n1     <= (n0 << 13) ^ n0;
        r_nn     <= r_n1 * r_n1;
        r_n2     <= r_n1;
        r_t3     <= r_nn * fvn_pkg::HASH_K1 + fvn_pkg::HASH_K2;
        r_n3     <= r_n2;
        r_t4     <= (r_n3 * r_t3 + fvn_pkg::HASH_K3) & fvn_pkg::HASH_MASK;
    end

endmodule
`default_nettype wire

// ===== sv/fvn_back.sv =====
// ----------------------------------------------------------------------------
// fractal value noise octave engine
// smooths, blends and weights each octave task, emits the saturated sum
// ----------------------------------------------------------------------------
`default_nettype none
`include "fractal_value_noise_2d_core_assert.svh"
module fvn_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fvn_pkg::t_oct_task             i_task,
    input  wire logic                           i_q_empty,
    input  wire logic [fvn_pkg::PERS_W-1:0]     i_persistence,
    output logic                                o_pop,
    output logic                                o_strobe,
    output logic [fvn_pkg::OUT_W-1:0]           o_noise_total
);

    localparam logic signed [fvn_pkg::RES_W-1:0] OUT_MAX =
        fvn_pkg::RES_W'((64'sd1 <<< (fvn_pkg::OUT_W - 1)) - 1);
    localparam logic signed [fvn_pkg::RES_W-1:0] OUT_MIN =
        fvn_pkg::RES_W'(-(64'sd1 <<< (fvn_pkg::OUT_W - 1)));

    fvn_pkg::t_back_state                   r_state;
    fvn_pkg::t_back_state                   n_state;
    fvn_pkg::t_oct_task                     r_task;
    logic [fvn_pkg::RAMP_W-1:0]             r_wx;
    logic [fvn_pkg::RAMP_W-1:0]             r_wy;
    logic [fvn_pkg::GRID_W-1:0]             r_gi;
    logic signed [fvn_pkg::SM_W-1:0]        r_v [4];
    logic signed [fvn_pkg::SM_W-1:0]        n_v [4];
    logic signed [fvn_pkg::SM_W-1:0]        r_top;
    logic signed [fvn_pkg::SM_W-1:0]        r_bot;
    logic signed [fvn_pkg::SM_W-1:0]        r_val;
    logic signed [fvn_pkg::PROD_W-1:0]      r_prod;
    logic signed [fvn_pkg::TERM_W-1:0]      r_term;
    logic signed [fvn_pkg::TOT_W-1:0]       r_total;
    logic [fvn_pkg::AMP_W-1:0]              r_amp;
    logic                                   r_strobe;
    logic [fvn_pkg::OUT_W-1:0]              r_res;

    logic                                   hv;
    logic [fvn_pkg::GRID_W-1:0]             htag;
    logic signed [fvn_pkg::LAT_W-1:0]       hval;
    logic                                   h_issue;
    logic [fvn_pkg::LAT_W-1:0]              hx;
    logic [fvn_pkg::LAT_W-1:0]              hy;

    logic signed [fvn_pkg::DIFF_W-1:0]      mul_a;
    logic [fvn_pkg::RAMP_W-1:0]             mul_f;
    logic signed [fvn_pkg::PROD_W-1:0]      prod;
    logic signed [fvn_pkg::SM_W-1:0]        blend_base;
    logic signed [fvn_pkg::SM_W-1:0]        blend_sum;
    logic signed [fvn_pkg::TERM_W-1:0]      term;
    logic [fvn_pkg::AMP_W+fvn_pkg::PERS_W-1:0] amp_prod;
    logic signed [fvn_pkg::RES_W-1:0]       res;
    logic [fvn_pkg::OUT_W-1:0]              sat;

    fvn_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h_issue),
        .i_x     (hx),
        .i_y     (hy),
        .i_tag   (r_gi),
        .o_valid (hv),
        .o_tag   (htag),
        .o_value (hval)
    );

    assign hx = r_task.ix + fvn_pkg::LAT_W'(r_gi[1:0]) - 1'b1;
    assign hy = r_task.iy + fvn_pkg::LAT_W'(r_gi[3:2]) - 1'b1;

    // 3x3 smoothing weights of each grid point onto the four cell corners
    always_comb begin
        int a;
        int b;
        int da;
        int db;
        int sh;
        a = int'(htag[1:0]);
        b = int'(htag[3:2]);
        for (int k = 0; k < 4; k++) begin
            da = a - (1 + k % 2);
            db = b - (1 + k / 2);
            sh = ((da == 0) ? 1 : 0) + ((db == 0) ? 1 : 0);
            n_v[k] = r_v[k];
            if (hv && da >= -1 && da <= 1 && db >= -1 && db <= 1) begin
                n_v[k] = r_v[k] + (fvn_pkg::SM_W'(hval) <<< sh);
            end
        end
    end

    always_comb begin
        mul_a      = fvn_pkg::DIFF_W'(r_v[1]) - fvn_pkg::DIFF_W'(r_v[0]);
        mul_f      = r_wx;
        blend_base = r_v[0];
        unique case (r_state)
            fvn_pkg::B_BOT: begin
                mul_a = fvn_pkg::DIFF_W'(r_v[3]) - fvn_pkg::DIFF_W'(r_v[2]);
            end
            fvn_pkg::B_MIX: begin
                blend_base = r_v[2];
            end
            fvn_pkg::B_VAL: begin
                mul_a = fvn_pkg::DIFF_W'(r_bot) - fvn_pkg::DIFF_W'(r_top);
                mul_f = r_wy;
            end
            fvn_pkg::B_OCT: begin
                blend_base = r_top;
            end
            default: begin
            end
        endcase
    end

    assign prod = fvn_pkg::PROD_W'(mul_a) * fvn_pkg::PROD_W'($signed({1'b0, mul_f}));
    assign blend_sum = fvn_pkg::SM_W'(fvn_pkg::PROD_W'(blend_base)
                     + (r_prod >>> fvn_pkg::RAMP_W));
    assign term = fvn_pkg::TERM_W'($signed(r_val[fvn_pkg::SM_W-1:fvn_pkg::OCTV_SH]))
                * fvn_pkg::TERM_W'($signed({1'b0, r_amp}));
    assign amp_prod = (fvn_pkg::AMP_W + fvn_pkg::PERS_W)'(r_amp)
                    * (fvn_pkg::AMP_W + fvn_pkg::PERS_W)'(i_persistence);
    assign res = r_total[fvn_pkg::TOT_W-1:fvn_pkg::RES_SH];

    always_comb begin
        priority if (res > OUT_MAX) begin
            sat = fvn_pkg::OUT_W'(OUT_MAX);
        end else if (res < OUT_MIN) begin
            sat = fvn_pkg::OUT_W'(OUT_MIN);
        end else begin
            sat = fvn_pkg::OUT_W'(res);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fvn_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_task.empty ? fvn_pkg::B_OUT : fvn_pkg::B_HASH;
                end
            end
            fvn_pkg::B_HASH: begin
                if (r_gi == fvn_pkg::GRID_W'(fvn_pkg::GRID_N - 1)) begin
                    n_state = fvn_pkg::B_WAIT;
                end
            end
            fvn_pkg::B_WAIT: begin
                if (hv && htag == fvn_pkg::GRID_W'(fvn_pkg::GRID_N - 1)) begin
                    n_state = fvn_pkg::B_TOP;
                end
            end
            fvn_pkg::B_TOP: n_state = fvn_pkg::B_BOT;
            fvn_pkg::B_BOT: n_state = fvn_pkg::B_MIX;
            fvn_pkg::B_MIX: n_state = fvn_pkg::B_VAL;
            fvn_pkg::B_VAL: n_state = fvn_pkg::B_OCT;
            fvn_pkg::B_OCT: n_state = fvn_pkg::B_ACC;
            fvn_pkg::B_ACC: n_state = fvn_pkg::B_AMP;
            fvn_pkg::B_AMP: n_state = r_task.last ? fvn_pkg::B_OUT : fvn_pkg::B_IDLE;
            fvn_pkg::B_OUT: n_state = fvn_pkg::B_IDLE;
            default:        n_state = fvn_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == fvn_pkg::B_IDLE) && !i_q_empty;
        h_issue = (r_state == fvn_pkg::B_HASH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fvn_pkg::B_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == fvn_pkg::B_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < 4; k++) begin
                r_v[k] <= '0;
            end
        end else begin
            r_v <= n_v;
        end
        if (o_pop) begin
            r_task <= i_task;
            r_wx   <= fvn_pkg::RAMP_ROM[i_task.fx];
            r_wy   <= fvn_pkg::RAMP_ROM[i_task.fy];
            r_gi   <= '0;
            if (i_task.first) begin
                r_total <= '0;
                r_amp   <= fvn_pkg::AMP_W'(1 << fvn_pkg::AMP_FRAC);
            end
        end
        if (h_issue) begin
            r_gi <= r_gi + 1'b1;
        end
        r_prod <= prod;
        if (r_state == fvn_pkg::B_BOT) begin
            r_top <= blend_sum;
        end
        if (r_state == fvn_pkg::B_MIX) begin
            r_bot <= blend_sum;
        end
        if (r_state == fvn_pkg::B_OCT) begin
            r_val <= blend_sum;
        end
        if (r_state == fvn_pkg::B_ACC) begin
            r_term <= term;
        end
        if (r_state == fvn_pkg::B_AMP) begin
            r_total <= r_total + fvn_pkg::TOT_W'(r_term);
            r_amp   <= amp_prod[fvn_pkg::AMP_W+fvn_pkg::PERS_FRAC-1:fvn_pkg::PERS_FRAC];
        end
        if (r_state == fvn_pkg::B_OUT) begin
            r_res <= sat;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_noise_total = r_res;

    `FVN_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_q_empty, "pop from empty queue")
    `FVN_ASSERT_IMP(a_hash_in_octave, i_clk, i_rst_n, hv,
        r_state == fvn_pkg::B_HASH || r_state == fvn_pkg::B_WAIT, "hash result outside octave")
    `FVN_ASSERT_NXT(a_out_strobe, i_clk, i_rst_n, r_state == fvn_pkg::B_OUT, o_strobe,
        "result strobe missing")

endmodule
`default_nettype wire

// ===== tb/sv/tb_fractal_value_noise_2d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal value noise core testbench
// drives coordinate pairs under changing octave and persistence settings,
// predicts each summed octave noise value in fixed point and compares it with
// the strobed result, with random gaps between transactions in most phases
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_2d_core;

    localparam logic [fvn_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = fvn_pkg::CFG_IDX_W'(2);
    localparam logic [fvn_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = fvn_pkg::CFG_IDX_W'(3);
    localparam int  N_PHASES    = 10;
    localparam int  PHASE_ITEMS = 125;
    localparam int  DRAIN_CYC   = 300;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [fvn_pkg::CNT_W-1:0]          oct;
        logic [fvn_pkg::PERS_W-1:0]         pers;
        logic signed [fvn_pkg::COORD_W-1:0] x;
        logic signed [fvn_pkg::COORD_W-1:0] y;
        bit                                 known;
        logic signed [fvn_pkg::OUT_W-1:0]   total;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_we;
    logic [fvn_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [fvn_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic signed [fvn_pkg::COORD_W-1:0] i_x_coord;
    logic signed [fvn_pkg::COORD_W-1:0] i_y_coord;
    logic o_noise_strobe;
    logic signed [fvn_pkg::OUT_W-1:0] o_noise_total;

    logic [fvn_pkg::RAMP_W-1:0] half_cos [fvn_pkg::RAMP_ENTRIES];
    logic [fvn_pkg::CNT_W-1:0]  cur_octaves;
    logic [fvn_pkg::PERS_W-1:0] cur_persist;
    logic signed [fvn_pkg::OUT_W-1:0] noise_fifo [$];
    int     mismatches;
    longint cycles;

    fractal_value_noise_2d_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .o_noise_strobe(o_noise_strobe), .o_noise_total(o_noise_total)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic void fill_half_cos();
        longint unsigned m, theta, th2, mag;
        longint c, f;
        for (int k = 0; k < fvn_pkg::RAMP_ENTRIES; k++) begin
            m     = (2 * k <= fvn_pkg::RAMP_ENTRIES) ? k : fvn_pkg::RAMP_ENTRIES - k;
            theta = (64'd3373259426 * m) / fvn_pkg::RAMP_ENTRIES;
            th2   = (theta * theta) >> 30;
            mag   = 64'd1073741824;
            c     = 64'sd1073741824;
            for (int n = 1; n <= 10; n++) begin
                mag = ((mag * th2) >> 30) / longint'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    c = c - longint'(mag);
                end else begin
                    c = c + longint'(mag);
                end
            end
            if (2 * k > fvn_pkg::RAMP_ENTRIES) begin
                c = -c;
            end
            f = (64'sd1073741824 - c + 64'sd16384) >>> 15;
            if (f < 0) f = 0;
            if (f > 65535) f = 65535;
            half_cos[k] = f[fvn_pkg::RAMP_W-1:0];
        end
    endfunction

    function automatic longint hash_point(logic [31:0] ix, logic [31:0] iy);
        logic [31:0] n, t;
        n = ix + iy * 32'd15731;
        n = (n << 13) ^ n;
        t = n * n * 32'd15731 + 32'd789221;
        t = (n * t + 32'd1376312589) & 32'h7fffffff;
        return 64'sd1073741824 - longint'({32'd0, t});
    endfunction

    function automatic longint smoothed(logic [31:0] x, logic [31:0] y);
        longint c, s;
        c = hash_point(x - 1, y - 1) + hash_point(x + 1, y - 1)
          + hash_point(x - 1, y + 1) + hash_point(x + 1, y + 1);
        s = hash_point(x - 1, y) + hash_point(x + 1, y)
          + hash_point(x, y - 1) + hash_point(x, y + 1);
        return c + 2 * s + 4 * hash_point(x, y);
    endfunction

    function automatic longint mix(longint a, longint b, logic [fvn_pkg::RAMP_W-1:0] f);
        return a + (((b - a) * longint'({48'd0, f})) >>> 16);
    endfunction

    function automatic void lattice_split(longint scaled, output logic [31:0] ip,
                                          output int idx);
        longint q, fr;
        q   = scaled / 65536;
        fr  = scaled - q * 65536;
        if (fr < 0) fr = -fr;
        ip  = q[31:0];
        idx = int'(((fr * fvn_pkg::RAMP_ENTRIES) >> fvn_pkg::FRAC_BITS)
                   % fvn_pkg::RAMP_ENTRIES);
    endfunction

    function automatic logic signed [fvn_pkg::OUT_W-1:0] noise_sum(logic signed [31:0] x,
                                                                  logic signed [31:0] y);
        int unsigned cnt;
        longint unsigned amp;
        longint total, top, bot, val, res;
        logic [31:0] ix, iy;
        int fx, fy;
        cnt   = (cur_octaves > fvn_pkg::MAX_OCTAVES) ? fvn_pkg::MAX_OCTAVES : cur_octaves;
        amp   = 64'd1 << 20;
        total = 0;
        for (int i = 0; i < cnt; i++) begin
            lattice_split(longint'(x) * (64'sd1 << i), ix, fx);
            lattice_split(longint'(y) * (64'sd1 << i), iy, fy);
            top = mix(smoothed(ix, iy), smoothed(ix + 1, iy), half_cos[fx]);
            bot = mix(smoothed(ix, iy + 1), smoothed(ix + 1, iy + 1), half_cos[fx]);
            val = mix(top, bot, half_cos[fy]);
            total += (val >>> 14) * longint'(amp);
            amp = (amp * cur_persist) >> 15;
        end
        res = total >>> 24;
        if (res > 2097151) res = 2097151;
        if (res < -2097152) res = -2097152;
        return res[fvn_pkg::OUT_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 260);
    endfunction

    function automatic logic [31:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom();
        if (r < 8) return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        if (r == 8) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fffffff}
                           ^ 32'($urandom_range(0, 255));
        return 32'h80000000 + 32'($urandom_range(0, 255));
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_noise_strobe) begin
            if (noise_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: noise_total %0d", o_noise_total);
            end else begin
                if (o_noise_total !== noise_fifo[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_total mismatch: expected %0d actual %0d",
                                 noise_fifo[0], o_noise_total);
                end
                void'(noise_fifo.pop_front());
            end
        end
    end

    task automatic wait_idle();
        while (noise_fifo.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [fvn_pkg::CNT_W-1:0] oct,
                                  logic [fvn_pkg::PERS_W-1:0] pers);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= fvn_pkg::CFG_OCTAVES;
        i_cfg_data <= fvn_pkg::CFG_DATA_W'($urandom_range(0, 65535) & 16'hfff0) | oct;
        cur_octaves = oct;
        @(posedge i_clk);
        i_cfg_idx  <= fvn_pkg::CFG_PERSIST;
        i_cfg_data <= pers;
        cur_persist = pers;
        @(posedge i_clk);
        i_cfg_idx  <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
        i_cfg_data <= fvn_pkg::CFG_DATA_W'($urandom());
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // start stays high across back-to-back transactions
    task automatic send_coord(logic signed [31:0] x, logic signed [31:0] y, int gap,
                              bit known, logic signed [fvn_pkg::OUT_W-1:0] total);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        noise_fifo.push_back(known ? total : noise_sum(x, y));
    endtask

    task automatic end_burst();
        @(posedge i_clk);
        start <= 1'b0;
    endtask

    t_row rows [$];
    logic [fvn_pkg::CNT_W-1:0] oct;
    logic [fvn_pkg::PERS_W-1:0] pers;
    bit no_gaps;

    initial begin
        fill_half_cos();
        mismatches  = 0;
        cycles      = 0;
        cur_octaves = fvn_pkg::OCT_RESET;
        cur_persist = fvn_pkg::PERS_RESET;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = fvn_pkg::CFG_OCTAVES;
        i_cfg_data  = '0;
        i_x_coord   = '0;
        i_y_coord   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first, then zero octaves, extremes and saturation
        rows = '{
            '{fvn_pkg::OCT_RESET, fvn_pkg::PERS_RESET, 32'sh0, 32'sh0, 0, 0},
            '{fvn_pkg::OCT_RESET, fvn_pkg::PERS_RESET, 32'sh7fffffff, 32'sh80000000, 0, 0},
            '{4'd0, 16'd0, 32'sh7fffffff, 32'sh7fffffff, 1, 0},
            '{4'd0, 16'd65535, 32'sh80000000, 32'sh12345678, 1, 0},
            '{4'd1, 16'd0, 32'sh00018000, 32'shfffe8000, 0, 0},
            '{4'd1, 16'd0, 32'shffffffff, 32'sh0000ffff, 0, 0},
            '{4'd8, 16'd65535, 32'sh80000000, 32'sh80000000, 0, 0},
            '{4'd8, 16'd65535, 32'sh7fffffff, 32'sh7fffffff, 0, 0},
            '{4'd8, 16'd65535, 32'sh00010000, 32'sh00020000, 0, 0},
            '{4'd8, 16'd65535, 32'shffff0000, 32'sh00000001, 0, 0},
            '{4'd15, 16'd40000, 32'sh40000000, 32'shc0000000, 0, 0},
            '{4'd9, 16'd32768, 32'sh7fff8000, 32'sh80008000, 0, 0},
            '{4'd3, 16'd16384, 32'sh00008000, 32'shffff8000, 0, 0},
            '{4'd3, 16'd16384, 32'shffffc000, 32'sh00004000, 0, 0},
            '{4'd5, 16'd1, 32'sh00123456, 32'shfedcba98, 0, 0}
        };
        foreach (rows[i]) begin
            if (rows[i].oct != cur_octaves || rows[i].pers != cur_persist) begin
                if (i != 0) end_burst();
                write_settings(rows[i].oct, rows[i].pers);
            end
            send_coord(rows[i].x, rows[i].y, 0, rows[i].known, rows[i].total);
        end
        end_burst();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin oct = 4'd1;  pers = 16'd16384; end
                1: begin oct = 4'd8;  pers = 16'd65535; end
                2: begin oct = 4'd0;  pers = 16'd0;     end
                3: begin oct = 4'd15; pers = 16'd0;     end
                4: begin oct = 4'd2;  pers = 16'd65535; end
                default: begin
                    oct  = fvn_pkg::CNT_W'($urandom_range(1, 9));
                    pers = fvn_pkg::PERS_W'($urandom());
                end
            endcase
            write_settings(oct, pers);
            no_gaps = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_coord(pick_coord(), pick_coord(), no_gaps ? 0 : pick_gap(), 0, 0);
            end_burst();
        end

        wait_idle();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && noise_fifo.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/fvn_pkg.sv
sv/fvn_queue.sv
sv/fvn_front.sv
sv/fvn_hash.sv
sv/fvn_back.sv
sv/fractal_value_noise_2d_core.sv
tb/sv/tb_fractal_value_noise_2d_core.sv
